// ----- rtl/hfc_pkg.sv -----
// hfc_pkg: shared types, constants and helpers for the half/single float converter
// used by every module in rtl; depends on nothing
`default_nettype none

package hfc_pkg;

	// conversion direction, carried in tuser
	typedef enum logic {
		OP_H2S = 1'b0,
		OP_S2H = 1'b1
	} op_t;

	// operand class decided in the unpack stage
	typedef enum logic [1:0] {
		CLS_ZERO,
		CLS_SUB,
		CLS_NORM,
		CLS_SPEC
	} cls_t;

	// bias difference between binary32 and binary16 exponents
	localparam logic [7:0] BIAS_ADJ = 8'd112;
	// smallest single exponent that still lands in the half subnormal range
	localparam logic [7:0] S2H_SUB_MIN = 8'd102;
	// first single exponent that overflows half
	localparam logic [7:0] S2H_OVF = 8'd143;
	// round half-up constant below the 13 dropped bits
	localparam logic [24:0] RND_BIAS = 25'h0001000;
	localparam logic [4:0] HALF_EXP_MAX = 5'h1F;
	localparam logic [7:0] SINGLE_EXP_MAX = 8'hFF;

	// unpack stage output
	typedef struct packed {
		op_t op;
		logic sign;
		cls_t cls;
		logic [7:0] expo;
		logic [22:0] man;
		logic [3:0] shamt;
	} s1_t;

	// align stage output
	typedef struct packed {
		op_t op;
		logic sign;
		cls_t cls;
		logic [7:0] expo;
		logic [23:0] mant;
	} s2_t;

	// shift that brings a nonzero 10-bit half subnormal mantissa up to bit 10
	function automatic logic [3:0] lz_shift(input logic [9:0] man);
		logic [3:0] pos;
		pos = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (man[i]) begin
				pos = 4'(i);
			end
		end
		return 4'd10 - pos;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/half_float_converter.sv -----
// half_float_converter: top level, three-stage binary16/binary32 converter
// depends on hfc_pkg, hfc_unpack, hfc_align, hfc_pack
//
// channel   dir  signals                    content
// s_axis    in   s_tvalid s_tready s_tdata   operand_bits[31:0]
//                s_tuser                     opcode (0 half to single, 1 single to half)
// m_axis    out  m_tvalid m_tready m_tdata   result_bits[31:0]
//
// three register stages: unpack/classify, mantissa shift, round and assemble;
// an accepted item passes the unpack, align and pack registers in turn;
// one item can enter every cycle unless the full pipeline is stalled.
// every stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up while the output is stalled.
// arst_n clears only the valid bits; payload registers are not reset.
`default_nettype none

module half_float_converter (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [31:0]   s_tdata,   // operand_bits[31:0]
	input  wire logic          s_tuser,   // opcode[0]
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [31:0]        m_tdata    // result_bits[31:0]
);

	logic v_s1;
	logic v_s2;
	logic en1;
	logic en2;
	logic en3;
	hfc_pkg::s1_t d_s1;
	hfc_pkg::s2_t d_s2;
	hfc_pkg::op_t op_s3;

	// per-stage load enables, a stage moves if empty or drained downstream
	assign en3 = !m_tvalid || m_tready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_tready = en1;

	hfc_unpack u_unpack (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en1),
		.vin          (s_tvalid),
		.opcode       (s_tuser),
		.operand_bits (s_tdata),
		.vout         (v_s1),
		.dout         (d_s1)
	);

	hfc_align u_align (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en2),
		.vin    (v_s1),
		.din    (d_s1),
		.vout   (v_s2),
		.dout   (d_s2)
	);

	hfc_pack u_pack (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en3),
		.vin    (v_s2),
		.din    (d_s2),
		.vout   (m_tvalid),
		.op_s3  (op_s3),
		.res_s3 (m_tdata)
	);

	// accepted item lands in the first stage
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted item did not reach stage 1");

	// full and stalled pipeline refuses input
	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while pipeline full and stalled");

	// an item in stage 2 moves to the output when the output frees
	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && en3 |=> m_tvalid)
		else $error("stage 2 item lost on the way to the output");

	// half results are zero-extended
	a_half_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && op_s3 == hfc_pkg::OP_S2H |-> m_tdata[31:16] == 16'h0000)
		else $error("half result has upper bits set");

endmodule

`default_nettype wire

// ----- rtl/hfc_unpack.sv -----
// hfc_unpack: first pipeline stage, splits the operand and classifies it
// depends on hfc_pkg
`default_nettype none

module hfc_unpack (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          vin,
	input  wire logic          opcode,
	input  wire logic [31:0]   operand_bits,
	output logic               vout,
	output hfc_pkg::s1_t       dout
);

	hfc_pkg::s1_t nxt;
	logic [4:0] hexp;
	logic [9:0] hman;
	logic [7:0] sexp;

	assign hexp = operand_bits[14:10];
	assign hman = operand_bits[9:0];
	assign sexp = operand_bits[30:23];

	// field split and class decode
	always_comb begin
		nxt.op    = hfc_pkg::op_t'(opcode);
		nxt.sign  = 1'b0;
		nxt.cls   = hfc_pkg::CLS_ZERO;
		nxt.expo  = 8'd0;
		nxt.man   = 23'd0;
		nxt.shamt = 4'd0;
		if (nxt.op == hfc_pkg::OP_H2S) begin
			nxt.sign = operand_bits[15];
			nxt.expo = {3'b000, hexp};
			nxt.man  = {13'd0, hman};
			if (hexp == 5'd0) begin
				if (hman == 10'd0) begin
					nxt.cls = hfc_pkg::CLS_ZERO;
				end else begin
					nxt.cls   = hfc_pkg::CLS_SUB;
					nxt.shamt = hfc_pkg::lz_shift(hman);
				end
			end else if (hexp == hfc_pkg::HALF_EXP_MAX) begin
				nxt.cls = hfc_pkg::CLS_SPEC;
			end else begin
				nxt.cls = hfc_pkg::CLS_NORM;
			end
		end else begin
			nxt.sign = operand_bits[31];
			nxt.expo = sexp;
			nxt.man  = operand_bits[22:0];
			if (sexp < hfc_pkg::S2H_SUB_MIN) begin
				nxt.cls = hfc_pkg::CLS_ZERO;
			end else if (sexp <= hfc_pkg::BIAS_ADJ) begin
				nxt.cls   = hfc_pkg::CLS_SUB;
				nxt.shamt = 4'(hfc_pkg::BIAS_ADJ + 8'd1 - sexp);
			end else if (sexp >= hfc_pkg::S2H_OVF) begin
				nxt.cls = hfc_pkg::CLS_SPEC;
			end else begin
				nxt.cls = hfc_pkg::CLS_NORM;
			end
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en && vin) begin
			dout <= nxt;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/hfc_align.sv -----
// hfc_align: second pipeline stage, normalizes or denormalizes the mantissa
// and rebiases the exponent; depends on hfc_pkg
`default_nettype none

module hfc_align (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          vin,
	input  wire hfc_pkg::s1_t  din,
	output logic               vout,
	output hfc_pkg::s2_t       dout
);

	hfc_pkg::s2_t nxt;

	// mantissa shift and exponent rebias
	always_comb begin
		nxt.op   = din.op;
		nxt.sign = din.sign;
		nxt.cls  = din.cls;
		nxt.expo = 8'd0;
		nxt.mant = 24'd0;
		if (din.op == hfc_pkg::OP_H2S) begin
			case (din.cls)
				hfc_pkg::CLS_SUB: begin
					nxt.expo = hfc_pkg::BIAS_ADJ + 8'd1 - {4'd0, din.shamt};
					nxt.mant = {14'd0, 10'(din.man[9:0] << din.shamt)};
				end
				hfc_pkg::CLS_NORM: begin
					nxt.expo = din.expo + hfc_pkg::BIAS_ADJ;
					nxt.mant = {14'd0, din.man[9:0]};
				end
				hfc_pkg::CLS_SPEC: begin
					nxt.expo = hfc_pkg::SINGLE_EXP_MAX;
					nxt.mant = {14'd0, din.man[9:0]};
				end
				default: begin
					nxt.expo = 8'd0;
					nxt.mant = 24'd0;
				end
			endcase
		end else begin
			case (din.cls)
				hfc_pkg::CLS_SUB: begin
					nxt.expo = 8'd0;
					nxt.mant = {1'b1, din.man} >> din.shamt;
				end
				hfc_pkg::CLS_NORM: begin
					nxt.expo = din.expo - hfc_pkg::BIAS_ADJ;
					nxt.mant = {1'b0, din.man};
				end
				default: begin
					nxt.expo = 8'd0;
					nxt.mant = 24'd0;
				end
			endcase
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en && vin) begin
			dout <= nxt;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/hfc_pack.sv -----
// hfc_pack: third pipeline stage, rounds and assembles the result word
// this register is the output register; depends on hfc_pkg
`default_nettype none

module hfc_pack (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          vin,
	input  wire hfc_pkg::s2_t  din,
	output logic               vout,
	output hfc_pkg::op_t       op_s3,
	output logic [31:0]        res_s3
);

	logic [24:0] rsum;
	logic [11:0] rnd;
	logic [14:0] mag;
	logic [31:0] nxt;

	// round half-up, carry runs into the exponent
	assign rsum = {1'b0, din.mant} + hfc_pkg::RND_BIAS;
	assign rnd  = rsum[24:13];
	assign mag  = {din.expo[4:0], 10'd0} + {3'd0, rnd};

	// result assembly
	always_comb begin
		nxt = 32'd0;
		if (din.op == hfc_pkg::OP_H2S) begin
			case (din.cls)
				hfc_pkg::CLS_ZERO: nxt = {din.sign, 31'd0};
				default:           nxt = {din.sign, din.expo, din.mant[9:0], 13'd0};
			endcase
		end else begin
			case (din.cls)
				hfc_pkg::CLS_ZERO: nxt = {16'd0, din.sign, 15'd0};
				hfc_pkg::CLS_SPEC: nxt = {16'd0, din.sign, hfc_pkg::HALF_EXP_MAX, 10'd0};
				default:           nxt = {16'd0, din.sign, mag};
			endcase
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en && vin) begin
			res_s3 <= nxt;
			op_s3  <= din.op;
		end
	end

endmodule

`default_nettype wire

// ----- test/half_float_converter_tb.sv -----
// half_float_converter_tb: self-checking bench for the binary16/binary32 converter
// drives random and corner-case operands under random backpressure and checks
// every result against an in-bench conversion; depends on hfc_pkg and the rtl
module half_float_converter_tb;

	localparam int N_RANDOM       = 630;
	localparam int CYCLE_LIMIT    = 60000;
	localparam int STALL_AT       = 100;
	localparam int STALL_CYCLES   = 60;
	localparam int QUIET_FROM     = 300;
	localparam int QUIET_TO       = 450;
	localparam int DRAIN_AT       = 520;
	localparam int IDLE_PCT       = 14;
	localparam int TAIL_CYCLES    = 12;
	localparam logic [31:0] ROUND_ADD = 32'h00001000;

	typedef struct {
		hfc_pkg::op_t op;
		logic [31:0]  bits;
	} operand_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = 32'd0;   // operand_bits[31:0]
	logic        s_tuser = 1'b0;    // opcode[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;           // result_bits[31:0]

	operand_item_t operand_q[$];
	logic [31:0]   expected_results[$];
	int            handed_out = 0;
	int            mismatches = 0;
	int            cycle_count = 0;
	bit            in_taken = 1'b0;
	int            stall_left = 0;
	bit            stall_done = 1'b0;

	half_float_converter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// exact widening of binary16 to binary32
	function automatic logic [31:0] widen_half(input logic [15:0] h);
		logic [31:0] sign;
		int unsigned ex;
		int unsigned man;
		int unsigned shift;
		sign = {h[15], 31'd0};
		ex = 32'(h[14:10]);
		man = 32'(h[9:0]);
		shift = 0;
		if (ex == 0) begin
			if (man == 0)
				return sign;
			// normalize the subnormal mantissa up to the hidden bit
			while ((man & 32'h400) == 0 && shift < 11) begin
				man = man << 1;
				shift++;
			end
			man = man & 32'h3FF;
			return sign | ((113 - shift) << 23) | (man << 13);
		end
		if (ex == 32'(hfc_pkg::HALF_EXP_MAX))
			return sign | 32'h7F800000 | (man << 13);
		return sign | ((ex + 112) << 23) | (man << 13);
	endfunction

	// binary32 to binary16 with half-up rounding, carry goes into the exponent
	function automatic logic [31:0] narrow_single(input logic [31:0] f);
		logic [31:0] sign;
		logic [31:0] man;
		int ex;
		sign = {16'd0, f[31], 15'd0};
		ex = int'(f[30:23]) - 112;
		man = {9'd0, f[22:0]};
		if (ex <= 0) begin
			if (ex < -10)
				return sign;
			man = (man | 32'h00800000) >> (1 - ex);
			return (sign | ((man + ROUND_ADD) >> 13)) & 32'h0000FFFF;
		end
		if (ex >= 31)
			return sign | 32'h00007C00;
		return (sign + ((32'(ex) << 10) + ((man + ROUND_ADD) >> 13))) & 32'h0000FFFF;
	endfunction

	function automatic logic [31:0] convert_operand(input hfc_pkg::op_t op,
			input logic [31:0] bits);
		if (op == hfc_pkg::OP_H2S)
			return widen_half(bits[15:0]);
		return narrow_single(bits);
	endfunction

	function automatic operand_item_t random_operand();
		operand_item_t it;
		int unsigned pick;
		it.op = hfc_pkg::op_t'(1'($urandom_range(1)));
		it.bits = $urandom();
		pick = $urandom_range(9);
		if (it.op == hfc_pkg::OP_S2H) begin
			// bias exponents toward the half range and its edges
			if (pick < 5)
				it.bits[30:23] = 8'($urandom_range(150, 98));
			else if (pick == 5)
				it.bits[30:23] = hfc_pkg::SINGLE_EXP_MAX;
			else if (pick == 6)
				it.bits[12:0] = $urandom_range(1) ? 13'h1000 : 13'h0FFF;
			else if (pick == 7) begin
				it.bits[30:23] = 8'($urandom_range(142, 112));
				it.bits[22:13] = 10'h3FF;
			end
		end else begin
			if (pick < 2)
				it.bits[14:10] = 5'd0;
			else if (pick == 2)
				it.bits[14:10] = hfc_pkg::HALF_EXP_MAX;
		end
		return it;
	endfunction

	task automatic queue_operand(input hfc_pkg::op_t op, input logic [31:0] bits);
		operand_item_t it;
		it.op = op;
		it.bits = bits;
		operand_q.push_back(it);
	endtask

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// sender: one item per handshake, random gaps, one drain pause
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || in_taken) begin
				if (operand_q.size() == 0
				    || (handed_out == DRAIN_AT && expected_results.size() != 0)
				    || (!(handed_out >= QUIET_FROM && handed_out < QUIET_TO)
				        && $urandom_range(99) < IDLE_PCT)) begin
					s_tvalid <= 1'b0;
				end else begin
					operand_item_t it;
					it = operand_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= it.bits;
					s_tuser <= it.op;
					handed_out++;
				end
			end
		end
	end

	// receiver: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!stall_done && handed_out >= STALL_AT) begin
				stall_done = 1'b1;
				stall_left = STALL_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= (handed_out >= QUIET_FROM && handed_out < QUIET_TO)
				            || $urandom_range(99) >= IDLE_PCT;
			end
		end
	end

	// monitor: predict on input handshake, compare on output handshake
	always @(posedge clk) begin
		logic [31:0] want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("half_float_converter_tb failed");
			$finish;
		end
		in_taken = arst_n && s_tvalid && s_tready;
		if (in_taken)
			expected_results.push_back(convert_operand(hfc_pkg::op_t'(s_tuser), s_tdata));
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("result_bits: no item expected, actual %h", m_tdata);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (m_tdata !== want) begin
					$error("result_bits: expected %h, actual %h", want, m_tdata);
					mismatches++;
				end
			end
		end
	end

	initial begin
		// half to single corners
		queue_operand(hfc_pkg::OP_H2S, 32'h00000000);   // positive zero
		queue_operand(hfc_pkg::OP_H2S, 32'h00008000);   // negative zero
		queue_operand(hfc_pkg::OP_H2S, 32'h00000001);   // smallest subnormal
		queue_operand(hfc_pkg::OP_H2S, 32'h000003FF);   // largest subnormal
		queue_operand(hfc_pkg::OP_H2S, 32'h00008200);   // negative subnormal
		queue_operand(hfc_pkg::OP_H2S, 32'h00003C00);   // one
		queue_operand(hfc_pkg::OP_H2S, 32'h00007BFF);   // largest normal
		queue_operand(hfc_pkg::OP_H2S, 32'h00007C00);   // infinity
		queue_operand(hfc_pkg::OP_H2S, 32'h0000FE01);   // nan with payload
		queue_operand(hfc_pkg::OP_H2S, 32'hFFFFBC00);   // upper half ignored
		// single to half corners
		queue_operand(hfc_pkg::OP_S2H, 32'h00000000);   // positive zero
		queue_operand(hfc_pkg::OP_S2H, 32'h80000000);   // negative zero
		queue_operand(hfc_pkg::OP_S2H, 32'h00000001);   // single subnormal
		queue_operand(hfc_pkg::OP_S2H, 32'h32800000);   // just below half subnormal range
		queue_operand(hfc_pkg::OP_S2H, 32'hB3000000);   // smallest half subnormal exponent
		queue_operand(hfc_pkg::OP_S2H, 32'h387FF000);   // subnormal rounds up to smallest normal
		queue_operand(hfc_pkg::OP_S2H, 32'h3F800000);   // one
		queue_operand(hfc_pkg::OP_S2H, 32'h3F801000);   // halfway, rounds up
		queue_operand(hfc_pkg::OP_S2H, 32'h3F800FFF);   // just below halfway
		queue_operand(hfc_pkg::OP_S2H, 32'hC77FE000);   // largest negative normal
		queue_operand(hfc_pkg::OP_S2H, 32'h477FF000);   // rounding carry out of top exponent
		queue_operand(hfc_pkg::OP_S2H, 32'h47800000);   // overflow
		queue_operand(hfc_pkg::OP_S2H, 32'hFF800000);   // negative infinity
		queue_operand(hfc_pkg::OP_S2H, 32'h7FC00001);   // nan loses payload
		queue_operand(hfc_pkg::OP_S2H, 32'hFFFFFFFF);   // all ones
		for (int i = 0; i < N_RANDOM; i++)
			operand_q.push_back(random_operand());

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (operand_q.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && !m_tvalid)
			$display("half_float_converter_tb passed");
		else
			$display("half_float_converter_tb failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/hfc_pkg.sv
rtl/hfc_unpack.sv
rtl/hfc_align.sv
rtl/hfc_pack.sv
rtl/half_float_converter.sv
test/half_float_converter_tb.sv
